// ----- src/focl_pkg.sv -----
// ----------------------------------------------------------------------------
// focl_pkg
// shared types, constants and helper functions of the field-oriented
// current loop: micro-op table, operand selects, trig coefficients
// ----------------------------------------------------------------------------
`default_nettype none

package focl_pkg;

	localparam int ADC_BITS  = 12;
	localparam int FRAC_BITS = 16;
	localparam int COEF_BITS = 30;
	localparam int DATA_W    = 32;
	localparam int AOP_W     = DATA_W + 2;
	localparam int BOP_W     = DATA_W + 1;
	localparam int ACC_W     = AOP_W + BOP_W;
	localparam int DIFF_W    = ADC_BITS + 1;
	localparam int STEP_W    = 5;
	localparam int NUM_STEPS = 32;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

	// Q2.30 coefficients
	localparam logic signed [BOP_W-1:0] C_ONE  = BOP_W'(1073741824);
	localparam logic signed [BOP_W-1:0] C_HALF = BOP_W'(536870912);
	localparam logic signed [BOP_W-1:0] C_S3H  = BOP_W'(929887697);
	localparam logic signed [BOP_W-1:0] C_IS3  = BOP_W'(619925131);

	localparam logic [ADC_BITS-1:0] OFFSET_RST = ADC_BITS'(2048);
	localparam logic [DATA_W-1:0]   SCALE_RST  = DATA_W'(65536);
	localparam logic [DATA_W-1:0]   KP_RST     = DATA_W'(65536);
	localparam logic [DATA_W-1:0]   KI_RST     = DATA_W'(6554);

	typedef enum logic [2:0] {
		CFG_ADC_OFFSET   = 3'd0,
		CFG_CUR_SCALE    = 3'd1,
		CFG_PROP_GAIN    = 3'd2,
		CFG_INTEG_GAIN   = 3'd3,
		CFG_TORQUE_REF   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		A_DA, A_DB, A_IAB, A_IA, A_IBETA, A_ERRD, A_ERRQ, A_PD, A_PQ, A_VAL, A_VBE
	} a_sel_t;

	typedef enum logic [3:0] {
		B_SCALE, B_IS3, B_COS, B_SIN, B_NSIN, B_KI, B_KP, B_NHALF, B_S3H, B_NS3H
	} b_sel_t;

	typedef enum logic [3:0] {
		D_IA, D_IB, D_IBETA, D_ID, D_IQ, D_FINT, D_PD, D_TINT, D_PQ, D_VAL, D_VBE, D_VB, D_VC
	} dest_t;

	typedef enum logic [1:0] {
		SH_NONE, SH_FRAC, SH_COEF
	} shift_t;

	typedef enum logic [1:0] {
		ADD_NONE, ADD_FINT, ADD_TINT
	} addend_t;

	typedef struct packed {
		logic    mac;
		logic    clr;
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    wb;
		dest_t   dest;
		shift_t  shift;
		addend_t addend;
	} uop_t;

	typedef struct packed {
		logic accept;
		logic load_out;
		uop_t op;
	} dp_cmd_t;

	function automatic uop_t mac_op(input a_sel_t a, input b_sel_t b, input logic clr);
		uop_t u;
		u = '0;
		u.mac   = 1'b1;
		u.clr   = clr;
		u.a_sel = a;
		u.b_sel = b;
		return u;
	endfunction

	function automatic uop_t wb_op(input dest_t d, input shift_t s, input addend_t ad);
		uop_t u;
		u = '0;
		u.wb     = 1'b1;
		u.dest   = d;
		u.shift  = s;
		u.addend = ad;
		return u;
	endfunction

	// micro-program of one item
	function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
		uop_t u;
		u = '0;
		case (step)
			5'd0:  u = mac_op(A_DA, B_SCALE, 1'b1);
			5'd1:  u = wb_op(D_IA, SH_NONE, ADD_NONE);
			5'd2:  u = mac_op(A_DB, B_SCALE, 1'b1);
			5'd3:  u = wb_op(D_IB, SH_NONE, ADD_NONE);
			5'd4:  u = mac_op(A_IAB, B_IS3, 1'b1);
			5'd5:  u = wb_op(D_IBETA, SH_COEF, ADD_NONE);
			5'd6:  u = mac_op(A_IA, B_COS, 1'b1);
			5'd7:  u = mac_op(A_IBETA, B_SIN, 1'b0);
			5'd8:  u = wb_op(D_ID, SH_COEF, ADD_NONE);
			5'd9:  u = mac_op(A_IA, B_NSIN, 1'b1);
			5'd10: u = mac_op(A_IBETA, B_COS, 1'b0);
			5'd11: u = wb_op(D_IQ, SH_COEF, ADD_NONE);
			5'd12: u = mac_op(A_ERRD, B_KI, 1'b1);
			5'd13: u = wb_op(D_FINT, SH_FRAC, ADD_FINT);
			5'd14: u = mac_op(A_ERRD, B_KP, 1'b1);
			5'd15: u = wb_op(D_PD, SH_FRAC, ADD_FINT);
			5'd16: u = mac_op(A_ERRQ, B_KI, 1'b1);
			5'd17: u = wb_op(D_TINT, SH_FRAC, ADD_TINT);
			5'd18: u = mac_op(A_ERRQ, B_KP, 1'b1);
			5'd19: u = wb_op(D_PQ, SH_FRAC, ADD_TINT);
			5'd20: u = mac_op(A_PD, B_COS, 1'b1);
			5'd21: u = mac_op(A_PQ, B_NSIN, 1'b0);
			5'd22: u = wb_op(D_VAL, SH_COEF, ADD_NONE);
			5'd23: u = mac_op(A_PD, B_SIN, 1'b1);
			5'd24: u = mac_op(A_PQ, B_COS, 1'b0);
			5'd25: u = wb_op(D_VBE, SH_COEF, ADD_NONE);
			5'd26: u = mac_op(A_VAL, B_NHALF, 1'b1);
			5'd27: u = mac_op(A_VBE, B_S3H, 1'b0);
			5'd28: u = wb_op(D_VB, SH_COEF, ADD_NONE);
			5'd29: u = mac_op(A_VAL, B_NHALF, 1'b1);
			5'd30: u = mac_op(A_VBE, B_NS3H, 1'b0);
			default: u = wb_op(D_VC, SH_COEF, ADD_NONE);
		endcase
		return u;
	endfunction

	// hall state to 60 degree sector, invalid states fall to sector 0
	function automatic logic [2:0] hall_sector(input logic [2:0] h);
		logic [2:0] s;
		case (h)
			3'b010:  s = 3'd1;
			3'b011:  s = 3'd5;
			3'b100:  s = 3'd2;
			3'b101:  s = 3'd3;
			3'b110:  s = 3'd4;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic signed [BOP_W-1:0] sin_coef(input logic [2:0] s);
		logic signed [BOP_W-1:0] c;
		case (s)
			3'd1, 3'd2: c = C_S3H;
			3'd4, 3'd5: c = -C_S3H;
			default:    c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [BOP_W-1:0] cos_coef(input logic [2:0] s);
		logic signed [BOP_W-1:0] c;
		case (s)
			3'd1, 3'd5: c = C_HALF;
			3'd2, 3'd4: c = -C_HALF;
			3'd3:       c = -C_ONE;
			default:    c = C_ONE;
		endcase
		return c;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > ACC_W'(64'sh7fffffff))
			r = 32'sh7fffffff;
		else if (v < -ACC_W'(64'sh80000000))
			r = 32'sh80000000;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/focl_if.sv -----
// ----------------------------------------------------------------------------
// focl channel interfaces
// valid/ready channels for sample transactions and voltage transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface focl_in_if;
	import focl_pkg::*;
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] sample_a;
	logic [ADC_BITS-1:0] sample_b;
	logic [2:0]          hall_bits;
	modport source (output valid, sample_a, sample_b, hall_bits, input ready);
	modport sink   (input valid, sample_a, sample_b, hall_bits, output ready);
endinterface

interface focl_out_if;
	import focl_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] volt_a;
	logic signed [DATA_W-1:0] volt_b;
	logic signed [DATA_W-1:0] volt_c;
	logic                     hall_invalid;
	modport source (output valid, volt_a, volt_b, volt_c, hall_invalid, input ready);
	modport sink   (input valid, volt_a, volt_b, volt_c, hall_invalid, output ready);
endinterface

`default_nettype wire

// ----- src/focl_ctrl.sv -----
// ----------------------------------------------------------------------------
// focl_ctrl
// sequencer: walks the micro-program once per transaction, owns handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module focl_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	output focl_pkg::dp_cmd_t        cmd
);
	import focl_pkg::*;

	ctrl_state_t         state_q, state_nx;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_RUN;
			ST_RUN:  if (step_q == LAST_STEP) state_nx = ST_OUT;
			ST_OUT:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RUN:  cmd.op = uop_rom(step_q);
			ST_OUT:  cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			step_q      <= (state_q == ST_RUN) ? step_q + 1'b1 : '0;
			out_valid_q <= cmd.load_out || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("accepted transaction did not start at step zero");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (step_q == LAST_STEP) |=> (state_q == ST_OUT))
		else $error("sequencer missed the output stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |=> (step_q == '0))
		else $error("step counter not cleared outside run");

endmodule

`default_nettype wire

// ----- src/focl_dpath.sv -----
// ----------------------------------------------------------------------------
// focl_dpath
// shared multiply-accumulate, round/saturate writeback, loop registers
// ----------------------------------------------------------------------------
`default_nettype none

module focl_dpath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [2:0]                         cfg_idx,
	input  wire  [focl_pkg::DATA_W-1:0]        cfg_data,
	input  wire  [focl_pkg::ADC_BITS-1:0]      sample_a,
	input  wire  [focl_pkg::ADC_BITS-1:0]      sample_b,
	input  wire  [2:0]                         hall_bits,
	input  focl_pkg::dp_cmd_t                  cmd,
	output logic signed [focl_pkg::DATA_W-1:0] volt_a,
	output logic signed [focl_pkg::DATA_W-1:0] volt_b,
	output logic signed [focl_pkg::DATA_W-1:0] volt_c,
	output logic                               hall_invalid
);
	import focl_pkg::*;

	logic [ADC_BITS-1:0]        offset_q;
	logic [DATA_W-1:0]          scale_q, kp_q, ki_q;
	logic signed [DATA_W-1:0]   tref_q;

	logic signed [DIFF_W-1:0]   da_q, db_q;
	logic [2:0]                 sec_q;
	logic                       inval_q;

	logic signed [DATA_W-1:0]   ia_q, ib_q, ibeta_q, id_q, iq_q, pd_q, pq_q;
	logic signed [DATA_W-1:0]   val_q, vbe_q, vb_q, vc_q;
	logic signed [DATA_W-1:0]   fint_q, tint_q;
	logic signed [ACC_W-1:0]    acc_q;

	logic signed [DATA_W-1:0]   err_d, err_q;
	logic signed [AOP_W-1:0]    a_op;
	logic signed [BOP_W-1:0]    b_op, sn, cs;
	logic signed [ACC_W-1:0]    prod, rnd, addend, wb_sum;
	logic signed [DATA_W-1:0]   wb_val;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			scale_q  <= SCALE_RST;
			kp_q     <= KP_RST;
			ki_q     <= KI_RST;
			tref_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ADC_OFFSET: offset_q <= cfg_data[ADC_BITS-1:0];
				CFG_CUR_SCALE:  scale_q  <= cfg_data;
				CFG_PROP_GAIN:  kp_q     <= cfg_data;
				CFG_INTEG_GAIN: ki_q     <= cfg_data;
				CFG_TORQUE_REF: tref_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture on accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			da_q    <= $signed({1'b0, sample_a}) - $signed({1'b0, offset_q});
			db_q    <= $signed({1'b0, sample_b}) - $signed({1'b0, offset_q});
			sec_q   <= hall_sector(hall_bits);
			inval_q <= (hall_bits == 3'b000) || (hall_bits == 3'b111);
		end
	end

	assign sn    = sin_coef(sec_q);
	assign cs    = cos_coef(sec_q);
	assign err_d = sat32(-ACC_W'(id_q));
	assign err_q = sat32(ACC_W'(tref_q) - ACC_W'(iq_q));

	always_comb begin
		case (cmd.op.a_sel)
			A_DA:    a_op = AOP_W'(da_q);
			A_DB:    a_op = AOP_W'(db_q);
			A_IAB:   a_op = AOP_W'(ia_q) + (AOP_W'(ib_q) <<< 1);
			A_IA:    a_op = AOP_W'(ia_q);
			A_IBETA: a_op = AOP_W'(ibeta_q);
			A_ERRD:  a_op = AOP_W'(err_d);
			A_ERRQ:  a_op = AOP_W'(err_q);
			A_PD:    a_op = AOP_W'(pd_q);
			A_PQ:    a_op = AOP_W'(pq_q);
			A_VAL:   a_op = AOP_W'(val_q);
			A_VBE:   a_op = AOP_W'(vbe_q);
			default: a_op = '0;
		endcase
	end

	always_comb begin
		case (cmd.op.b_sel)
			B_SCALE: b_op = $signed({1'b0, scale_q});
			B_IS3:   b_op = C_IS3;
			B_COS:   b_op = cs;
			B_SIN:   b_op = sn;
			B_NSIN:  b_op = -sn;
			B_KI:    b_op = $signed({1'b0, ki_q});
			B_KP:    b_op = $signed({1'b0, kp_q});
			B_NHALF: b_op = -C_HALF;
			B_S3H:   b_op = C_S3H;
			B_NS3H:  b_op = -C_S3H;
			default: b_op = '0;
		endcase
	end

	assign prod = ACC_W'(a_op) * ACC_W'(b_op);

	always_ff @(posedge clk) begin
		if (cmd.op.mac)
			acc_q <= (cmd.op.clr ? '0 : acc_q) + prod;
	end

	// round half up then floor shift, add integrator, saturate
	always_comb begin
		case (cmd.op.shift)
			SH_FRAC: rnd = (acc_q + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			SH_COEF: rnd = (acc_q + (ACC_W'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
			default: rnd = acc_q;
		endcase
		case (cmd.op.addend)
			ADD_FINT: addend = ACC_W'(fint_q);
			ADD_TINT: addend = ACC_W'(tint_q);
			default:  addend = '0;
		endcase
		wb_sum = rnd + addend;
		wb_val = sat32(wb_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fint_q <= '0;
			tint_q <= '0;
		end else if (cmd.op.wb) begin
			if (cmd.op.dest == D_FINT) fint_q <= wb_val;
			if (cmd.op.dest == D_TINT) tint_q <= wb_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op.wb) begin
			case (cmd.op.dest)
				D_IA:    ia_q    <= wb_val;
				D_IB:    ib_q    <= wb_val;
				D_IBETA: ibeta_q <= wb_val;
				D_ID:    id_q    <= wb_val;
				D_IQ:    iq_q    <= wb_val;
				D_PD:    pd_q    <= wb_val;
				D_PQ:    pq_q    <= wb_val;
				D_VAL:   val_q   <= wb_val;
				D_VBE:   vbe_q   <= wb_val;
				D_VB:    vb_q    <= wb_val;
				D_VC:    vc_q    <= wb_val;
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			volt_a       <= val_q;
			volt_b       <= vb_q;
			volt_c       <= vc_q;
			hall_invalid <= inval_q;
		end
	end

endmodule

`default_nettype wire

// ----- src/foc_current_loop_top.sv -----
// ----------------------------------------------------------------------------
// foc_current_loop_top
// hall-sensored field-oriented current loop: clarke/park, two PI loops,
// inverse park/clarke, one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// usage
//  - in_ch carries one transaction per PWM period: two phase-current ADC
//    samples and the hall state; out_ch returns three saturated Q16.16
//    phase voltages and a flag for the illegal hall states 000 and 111
//  - cfg_we/cfg_idx/cfg_data write offset, scale, gains and Iq reference;
//    write them only while no transaction is in flight
//  - in_ch.ready is high only in idle; one transaction is worked at a time
//  - a transaction passes the accept in idle, the micro-program on the shared
//    34x33 multiplier (19 products, 13 round/saturate writebacks) and the
//    output load into the registered out_ch; the next transaction is
//    accepted only once that load is done, also when out_ch is not stalled
//  - the result sits in an output register; a new transaction can be
//    accepted and computed while it waits, the load then holds until
//    out_ch.ready frees the register
//  - reset clears both integrators and restores register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module foc_current_loop_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [2:0]                   cfg_idx,
	input  wire  [focl_pkg::DATA_W-1:0]  cfg_data,
	focl_in_if.sink                      in_ch,
	focl_out_if.source                   out_ch
);
	import focl_pkg::*;

	// command bundle from sequencer to datapath
	dp_cmd_t cmd;

	focl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	focl_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.sample_a     (in_ch.sample_a),
		.sample_b     (in_ch.sample_b),
		.hall_bits    (in_ch.hall_bits),
		.cmd          (cmd),
		.volt_a       (out_ch.volt_a),
		.volt_b       (out_ch.volt_b),
		.volt_c       (out_ch.volt_c),
		.hall_invalid (out_ch.hall_invalid)
	);

endmodule

`default_nettype wire
